>>> sv/btlv_pkg.sv
`default_nettype none

package btlv_pkg;

  localparam int unsigned TagWidth    = 24;
  localparam int unsigned LengthWidth = 32;

  localparam logic [1:0] ROLE_PAD    = 2'd0;
  localparam logic [1:0] ROLE_TAG    = 2'd1;
  localparam logic [1:0] ROLE_LENGTH = 2'd2;
  localparam logic [1:0] ROLE_VALUE  = 2'd3;

  typedef struct packed {
    logic [1:0]             role;
    logic [7:0]             data;
    logic [TagWidth-1:0]    tag;
    logic [1:0]             tag_bytes;
    logic [LengthWidth-1:0] length;
    logic                   header_done;
    logic                   element_end;
    logic                   clamped;
  } result_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

endpackage

`default_nettype wire

>>> sv/btlv_front.sv
`default_nettype none

module btlv_front #(
  parameter int unsigned MAX_TAG_BYTES    = 3,
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       data_byte,
  input  wire logic             stream_start,
  input  wire btlv_pkg::q_wr_t  q_status,
  output btlv_pkg::q_wr_t       q_ctrl,
  output btlv_pkg::result_t     result
);

  localparam int unsigned TCW = $clog2(MAX_TAG_BYTES + 1);
  localparam int unsigned LCW = $clog2(MAX_LENGTH_BYTES + 1);

  localparam logic [2:0] PH_TAG_FIRST = 3'd0;
  localparam logic [2:0] PH_TAG_MORE  = 3'd1;
  localparam logic [2:0] PH_LEN_FIRST = 3'd2;
  localparam logic [2:0] PH_LEN_MORE  = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;

  logic [2:0]                       phase, phase_next, phase_base;
  logic [btlv_pkg::TagWidth-1:0]    tag_acc, tag_acc_next, tag_acc_base;
  logic [TCW-1:0]                   tag_cnt, tag_cnt_next, tag_cnt_base;
  logic [LCW-1:0]                   len_left, len_left_next, len_left_base, len_left_dec;
  logic [btlv_pkg::LengthWidth-1:0] len_acc, len_acc_next, len_acc_base;
  logic [btlv_pkg::LengthWidth-1:0] val_left, val_left_next, val_left_base, val_left_dec;
  logic                             clamp, clamp_next, clamp_base;
  logic                             finish, hdr, fin_end, val_end;
  logic [1:0]                       role;
  logic [2:0]                       cnt_ext;
  logic                             accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    phase_base    = stream_start ? PH_TAG_FIRST : phase;
    tag_acc_base  = stream_start ? '0 : tag_acc;
    tag_cnt_base  = stream_start ? '0 : tag_cnt;
    len_left_base = stream_start ? '0 : len_left;
    len_acc_base  = stream_start ? '0 : len_acc;
    val_left_base = stream_start ? '0 : val_left;
    clamp_base    = stream_start ? 1'b0 : clamp;

    phase_next    = phase_base;
    tag_acc_next  = tag_acc_base;
    tag_cnt_next  = tag_cnt_base;
    len_left_next = len_left_base;
    len_acc_next  = len_acc_base;
    val_left_next = val_left_base;
    clamp_next    = clamp_base;
    finish        = 1'b0;
    val_end       = 1'b0;
    role          = btlv_pkg::ROLE_PAD;

    len_left_dec = (len_left_base != '0) ? len_left_base - 1'b1 : len_left_base;
    val_left_dec = (val_left_base != '0) ? val_left_base - 1'b1 : val_left_base;

    unique case (phase_base)
      PH_TAG_MORE: begin
        role         = btlv_pkg::ROLE_TAG;
        tag_acc_next = {tag_acc_base[btlv_pkg::TagWidth-9:0], data_byte};
        tag_cnt_next = tag_cnt_base + 1'b1;
        if (data_byte[7] && (tag_cnt_next < TCW'(MAX_TAG_BYTES))) begin
          phase_next = PH_TAG_MORE;
        end else begin
          phase_next = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        role = btlv_pkg::ROLE_LENGTH;
        if (!data_byte[7]) begin
          len_acc_next = btlv_pkg::LengthWidth'(data_byte);
          finish       = 1'b1;
        end else begin
          len_acc_next = '0;
          if (data_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
            len_left_next = LCW'(MAX_LENGTH_BYTES);
            clamp_next    = 1'b1;
          end else begin
            len_left_next = LCW'(data_byte[6:0]);
          end
          if (data_byte[6:0] == 7'd0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_LEN_MORE;
          end
        end
      end
      PH_LEN_MORE: begin
        role          = btlv_pkg::ROLE_LENGTH;
        len_acc_next  = {len_acc_base[btlv_pkg::LengthWidth-9:0], data_byte};
        len_left_next = len_left_dec;
        finish        = (len_left_dec == '0);
      end
      PH_VALUE: begin
        role          = btlv_pkg::ROLE_VALUE;
        val_left_next = val_left_dec;
        if (val_left_dec == '0) begin
          val_end    = 1'b1;
          phase_next = PH_TAG_FIRST;
        end
      end
      default: begin
        tag_acc_next  = '0;
        tag_cnt_next  = '0;
        len_left_next = '0;
        len_acc_next  = '0;
        val_left_next = '0;
        clamp_next    = 1'b0;
        phase_next    = PH_TAG_FIRST;
        if (data_byte != 8'd0) begin
          role         = btlv_pkg::ROLE_TAG;
          tag_acc_next = btlv_pkg::TagWidth'(data_byte);
          tag_cnt_next = TCW'(1);
          if ((data_byte[4:0] == 5'h1F) && (TCW'(1) < TCW'(MAX_TAG_BYTES))) begin
            phase_next = PH_TAG_MORE;
          end else begin
            phase_next = PH_LEN_FIRST;
          end
        end
      end
    endcase

    hdr     = finish;
    fin_end = 1'b0;
    if (finish) begin
      if (len_acc_next == '0) begin
        fin_end    = 1'b1;
        phase_next = PH_TAG_FIRST;
      end else begin
        val_left_next = len_acc_next;
        phase_next    = PH_VALUE;
      end
    end
  end

  assign cnt_ext = 3'(tag_cnt_next);

  always_comb begin
    result.role        = role;
    result.data        = data_byte;
    result.tag         = tag_acc_next;
    result.tag_bytes   = cnt_ext[1:0];
    result.length      = len_acc_next;
    result.header_done = hdr;
    result.element_end = fin_end || val_end;
    result.clamped     = clamp_next;
    q_ctrl.push        = accept;
    q_ctrl.full        = q_status.full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TAG_FIRST;
      tag_acc  <= '0;
      tag_cnt  <= '0;
      len_left <= '0;
      len_acc  <= '0;
      val_left <= '0;
      clamp    <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      tag_acc  <= tag_acc_next;
      tag_cnt  <= tag_cnt_next;
      len_left <= len_left_next;
      len_acc  <= len_acc_next;
      val_left <= val_left_next;
      clamp    <= clamp_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/btlv_queue.sv
`default_nettype none

module btlv_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire btlv_pkg::q_wr_t   wr_ctrl,
  output btlv_pkg::q_wr_t        wr_status,
  input  wire btlv_pkg::result_t wr_data,
  input  wire btlv_pkg::q_rd_t   rd_ctrl,
  output btlv_pkg::q_rd_t        rd_status,
  output btlv_pkg::result_t      rd_data
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  btlv_pkg::result_t entries [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr, rd_ptr_next;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign do_push = wr_ctrl.push && (count != CW'(DEPTH));
  assign do_pop  = rd_ctrl.pop && (count != '0);

  always_comb begin
    wr_status.push  = do_push;
    wr_status.full  = (count == CW'(DEPTH));
    rd_status.pop   = do_pop;
    rd_status.empty = (count == '0);
    rd_ptr_next     = rd_ptr;
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
    // pass the beat straight to the head when it lands in a queue that is empty or emptied by this cycle's pop
    if (do_push && (wr_ptr == rd_ptr_next)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= entries[rd_ptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      rd_ptr <= rd_ptr_next;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/btlv_back.sv
`default_nettype none

module btlv_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire btlv_pkg::q_rd_t   q_status,
  output btlv_pkg::q_rd_t        q_ctrl,
  input  wire btlv_pkg::result_t head,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output btlv_pkg::result_t      out_data
);

  logic load;

  assign load = !q_status.empty && (!out_valid || !out_stall);

  always_comb begin
    q_ctrl.pop   = load;
    q_ctrl.empty = q_status.empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= head;
    end
  end

endmodule

`default_nettype wire

>>> sv/ber_tlv_stream_parser_top.sv
// BER-TLV stream parser: one byte of the stream per input beat, one result beat per byte.
// Input channel: in_valid/in_stall with data_byte and stream_start; stream_start set
// on a beat restarts parsing so that byte is taken as a first tag byte (zero = padding).
// Output channel: out_valid/out_stall with the byte's role, the byte itself, the running
// tag, tag byte count, value length and the header_done, element_end and
// length_clamped flags of the current element.
// Throughput: one beat per cycle in both directions while no stall is raised; the parser
// state updates once per accepted byte, so consecutive bytes can go in on consecutive cycles.
// Output path: the parser's result for a beat is written into the queue, then moves from
// the queue head into the output register.
// Stall: the queue between parser and output register holds QUEUE_DEPTH beats;
// in_stall rises only once it is full while out_stall is held.
// Reset: rst clears the parser to expect a first tag byte, empties the queue and
// drops out_valid; no clearing pass is needed.
`default_nettype none

module ber_tlv_stream_parser_top #(
  parameter int unsigned MAX_TAG_BYTES    = 3,
  parameter int unsigned MAX_LENGTH_BYTES = 4,
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        stream_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       byte_role,
  output logic [7:0]       data_out,
  output logic [23:0]      tag_value,
  output logic [1:0]       tag_bytes,
  output logic [31:0]      value_length,
  output logic             header_done,
  output logic             element_end,
  output logic             length_clamped
);

  btlv_pkg::q_wr_t   wr_ctrl, wr_status;
  btlv_pkg::q_rd_t   rd_ctrl, rd_status;
  btlv_pkg::result_t front_result, head, out_data;

  btlv_front #(
    .MAX_TAG_BYTES   (MAX_TAG_BYTES),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .stream_start(stream_start),
    .q_status    (wr_status),
    .q_ctrl      (wr_ctrl),
    .result      (front_result)
  );

  btlv_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_ctrl  (wr_ctrl),
    .wr_status(wr_status),
    .wr_data  (front_result),
    .rd_ctrl  (rd_ctrl),
    .rd_status(rd_status),
    .rd_data  (head)
  );

  btlv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (rd_status),
    .q_ctrl   (rd_ctrl),
    .head     (head),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign byte_role      = out_data.role;
  assign data_out       = out_data.data;
  assign tag_value      = out_data.tag;
  assign tag_bytes      = out_data.tag_bytes;
  assign value_length   = out_data.length;
  assign header_done    = out_data.header_done;
  assign element_end    = out_data.element_end;
  assign length_clamped = out_data.clamped;

endmodule

`default_nettype wire

>>> sv/btlv_checker.sv
`default_nettype none

module btlv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  byte_role,
  input wire logic [23:0] tag_value,
  input wire logic [1:0]  tag_bytes,
  input wire logic [31:0] value_length,
  input wire logic        header_done,
  input wire logic        element_end,
  input wire logic        length_clamped
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_hdr_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_done |-> byte_role == btlv_pkg::ROLE_LENGTH)
    else $error("header done on a byte that is not a length byte");

  a_pad_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == btlv_pkg::ROLE_PAD |->
      tag_value == 24'd0 && tag_bytes == 2'd0 && value_length == 32'd0 && !length_clamped)
    else $error("padding byte carries element state");

  a_end_place: assert property (@(posedge clk) disable iff (rst)
    out_valid && element_end |->
      byte_role == btlv_pkg::ROLE_VALUE || (header_done && value_length == 32'd0))
    else $error("element end on an unexpected byte");

endmodule

bind ber_tlv_stream_parser_top btlv_checker u_btlv_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .byte_role     (byte_role),
  .tag_value     (tag_value),
  .tag_bytes     (tag_bytes),
  .value_length  (value_length),
  .header_done   (header_done),
  .element_end   (element_end),
  .length_clamped(length_clamped)
);

`default_nettype wire
